FILE: sv/miq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and constants of the middle insert queue.
// ----------------------------------------------------------------------------
package miq_pkg;

   // fixed widths of the item fields
   localparam int OP_W     = 2;
   localparam int ITEM_W   = 31;
   localparam int STATUS_W = 2;

   // request codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage
`default_nettype wire

FILE: sv/miq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// miq_req_if / miq_rsp_if
// Valid/ready channels carrying queue requests and responses.
// ----------------------------------------------------------------------------
interface miq_req_if import miq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ITEM_W-1:0] item_value;

   modport source (output valid, output op, output item_value, input ready);
   modport sink   (input valid, input op, input item_value, output ready);
endinterface

interface miq_rsp_if import miq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ITEM_W-1:0]   popped_value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink   (input valid, input popped_value, input status, output ready);
endinterface
`default_nettype wire

FILE: sv/middle_insert_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A response is registered when its item commits in the execute state. No
// new item is taken before the last is done: on acceptance in idle both ring
// heads are read from their rams, then execute writes the rings and updates
// pointers. An item that owes a response waits while the previous response
// is held. Reset clears the ring pointers, counts and response valid; the
// ring rams are not cleared and the queue is usable once reset is released.
// ----------------------------------------------------------------------------
// middle_insert_queue_core
// FIFO queue with tail push, middle insert and head pop, kept as two rings.
// ----------------------------------------------------------------------------
module middle_insert_queue_core import miq_pkg::*; #(
   parameter int HALF_DEPTH = 512,
   parameter int VALUE_BITS = 31
) (
   input  wire logic clock,
   input  wire logic reset,
   miq_req_if.sink   req_if,
   miq_rsp_if.source rsp_if
);

   localparam int STORE_W = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
   localparam int AW      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int CW      = $clog2(HALF_DEPTH + 1);

   logic               front_wr_en, front_rd_en;
   logic [AW-1:0]      front_wr_addr, front_rd_addr;
   logic [STORE_W-1:0] front_wr_data, front_rd_data;
   logic               back_wr_en, back_rd_en;
   logic [AW-1:0]      back_wr_addr, back_rd_addr;
   logic [STORE_W-1:0] back_wr_data, back_rd_data;

   // front half ring
   miq_ram #(
      .DEPTH  (HALF_DEPTH),
      .WIDTH  (STORE_W),
      .ADDR_W (AW)
   ) u_front_ram (
      .clock   (clock),
      .wr_en   (front_wr_en),
      .wr_addr (front_wr_addr),
      .wr_data (front_wr_data),
      .rd_en   (front_rd_en),
      .rd_addr (front_rd_addr),
      .rd_data (front_rd_data)
   );

   // back half ring
   miq_ram #(
      .DEPTH  (HALF_DEPTH),
      .WIDTH  (STORE_W),
      .ADDR_W (AW)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (back_wr_en),
      .wr_addr (back_wr_addr),
      .wr_data (back_wr_data),
      .rd_en   (back_rd_en),
      .rd_addr (back_rd_addr),
      .rd_data (back_rd_data)
   );

   // sequencing and pointers
   miq_ctrl #(
      .HALF_DEPTH (HALF_DEPTH),
      .STORE_W    (STORE_W),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .front_wr_en   (front_wr_en),
      .front_wr_addr (front_wr_addr),
      .front_wr_data (front_wr_data),
      .front_rd_en   (front_rd_en),
      .front_rd_addr (front_rd_addr),
      .front_rd_data (front_rd_data),
      .back_wr_en    (back_wr_en),
      .back_wr_addr  (back_wr_addr),
      .back_wr_data  (back_wr_data),
      .back_rd_en    (back_rd_en),
      .back_rd_addr  (back_rd_addr),
      .back_rd_data  (back_rd_data)
   );

endmodule
`default_nettype wire

FILE: sv/miq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// miq_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module miq_ram #(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 31,
   parameter int ADDR_W = 9
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/miq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// miq_ctrl
// Ring pointers, request sequencing and response register of the queue.
// ----------------------------------------------------------------------------
module miq_ctrl import miq_pkg::*; #(
   parameter int HALF_DEPTH = 512,
   parameter int STORE_W    = 31,
   parameter int AW         = 9,
   parameter int CW         = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   miq_req_if.sink                 req_if,
   miq_rsp_if.source               rsp_if,
   // front ring
   output      logic               front_wr_en,
   output      logic [AW-1:0]      front_wr_addr,
   output      logic [STORE_W-1:0] front_wr_data,
   output      logic               front_rd_en,
   output      logic [AW-1:0]      front_rd_addr,
   input  wire logic [STORE_W-1:0] front_rd_data,
   // back ring
   output      logic               back_wr_en,
   output      logic [AW-1:0]      back_wr_addr,
   output      logic [STORE_W-1:0] back_wr_data,
   output      logic               back_rd_en,
   output      logic [AW-1:0]      back_rd_addr,
   input  wire logic [STORE_W-1:0] back_rd_data
);

   localparam int SUM_W = AW + 2;
   localparam logic [SUM_W-1:0] RING_N   = SUM_W'(HALF_DEPTH);
   localparam logic [AW-1:0]    LAST_IDX = AW'(HALF_DEPTH - 1);
   localparam logic [CW:0]      CAP      = (CW + 1)'(2 * HALF_DEPTH);

   state_type          state_ff, state_in;
   logic [AW-1:0]      fhead_ff, fhead_in;
   logic [CW-1:0]      fcount_ff, fcount_in;
   logic [AW-1:0]      bhead_ff, bhead_in;
   logic [CW-1:0]      bcount_ff, bcount_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [STORE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic [SUM_W-1:0]   ftail_sum, btail_sum;
   logic [AW-1:0]      ftail, btail, fnext, bnext, bprev;
   logic [CW:0]        total;
   logic               full;
   logic               need_rsp;
   logic               commit;
   logic               res_en;
   logic [ITEM_W-1:0]  res_value;
   status_type         res_status;

   assign accept         = req_if.valid && req_if.ready;
   assign req_if.ready   = (state_ff == ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.popped_value = rsp_value_ff;
   assign rsp_if.status  = rsp_status_ff;

   // both ring heads are read when an item is taken
   assign front_rd_en   = accept;
   assign front_rd_addr = fhead_ff;
   assign back_rd_en    = accept;
   assign back_rd_addr  = bhead_ff;

   // ring index arithmetic
   always_comb begin
      ftail_sum = SUM_W'(fhead_ff) + SUM_W'(fcount_ff);
      btail_sum = SUM_W'(bhead_ff) + SUM_W'(bcount_ff);
      ftail = (ftail_sum >= RING_N) ? AW'(ftail_sum - RING_N) : AW'(ftail_sum);
      btail = (btail_sum >= RING_N) ? AW'(btail_sum - RING_N) : AW'(btail_sum);
      fnext = (fhead_ff == LAST_IDX) ? '0 : fhead_ff + AW'(1);
      bnext = (bhead_ff == LAST_IDX) ? '0 : bhead_ff + AW'(1);
      bprev = (bhead_ff == '0) ? LAST_IDX : bhead_ff - AW'(1);
      total = (CW + 1)'(fcount_ff) + (CW + 1)'(bcount_ff);
      full  = (total >= CAP);
   end

   // does the held item produce a response, and can it finish now
   always_comb begin
      unique case (op_type'(op_ff))
         OP_PUSH, OP_INSERT: need_rsp = full;
         OP_POP:             need_rsp = 1'b1;
         default:            need_rsp = 1'b0;
      endcase
      commit = (state_ff == ST_EXEC) && !(need_rsp && rsp_valid_ff && !rsp_if.ready);
   end

   // request execution: ring writes, pointer updates, response
   always_comb begin
      fhead_in      = fhead_ff;
      fcount_in     = fcount_ff;
      bhead_in      = bhead_ff;
      bcount_in     = bcount_ff;
      front_wr_en   = 1'b0;
      front_wr_addr = ftail;
      front_wr_data = value_ff;
      back_wr_en    = 1'b0;
      back_wr_addr  = btail;
      back_wr_data  = value_ff;
      res_en        = 1'b0;
      res_value     = '0;
      res_status    = STATUS_OK;

      if (commit) begin
         unique case (op_type'(op_ff))
            OP_PUSH: begin
               if (full) begin
                  res_en     = 1'b1;
                  res_status = STATUS_FULL;
               end else if (fcount_ff == '0 && bcount_ff == '0) begin
                  front_wr_en = 1'b1;
                  fcount_in   = fcount_ff + CW'(1);
               end else if (bcount_ff >= fcount_ff) begin
                  // shift the back start over to the front, then append
                  front_wr_en   = 1'b1;
                  front_wr_data = back_rd_data;
                  fcount_in     = fcount_ff + CW'(1);
                  bhead_in      = bnext;
                  back_wr_en    = 1'b1;
               end else begin
                  back_wr_en = 1'b1;
                  bcount_in  = bcount_ff + CW'(1);
               end
            end
            OP_INSERT: begin
               if (full) begin
                  res_en     = 1'b1;
                  res_status = STATUS_FULL;
               end else if (fcount_ff > bcount_ff) begin
                  // goes to the start of the back half
                  back_wr_en   = 1'b1;
                  back_wr_addr = bprev;
                  bhead_in     = bprev;
                  bcount_in    = bcount_ff + CW'(1);
               end else begin
                  front_wr_en = 1'b1;
                  fcount_in   = fcount_ff + CW'(1);
               end
            end
            OP_POP: begin
               res_en = 1'b1;
               if (fcount_ff == '0) begin
                  res_status = STATUS_EMPTY;
               end else begin
                  res_value = ITEM_W'(front_rd_data);
                  fhead_in  = fnext;
                  if (bcount_ff >= fcount_ff) begin
                     // rebalance: back start moves to the front tail
                     front_wr_en   = 1'b1;
                     front_wr_data = back_rd_data;
                     bhead_in      = bnext;
                     bcount_in     = bcount_ff - CW'(1);
                  end else begin
                     fcount_in = fcount_ff - CW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (res_en) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
      end
   end

   // next state and item capture
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      value_in = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               op_in    = req_if.op;
               value_in = req_if.item_value[STORE_W-1:0];
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fhead_ff     <= '0;
         fcount_ff    <= '0;
         bhead_ff     <= '0;
         bcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fhead_ff     <= fhead_in;
         fcount_ff    <= fcount_in;
         bhead_ff     <= bhead_in;
         bcount_ff    <= bcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
`default_nettype wire
